### hdl/polyline_simplifier_macros.svh
// Shared assertion macros for the polyline simplifier checks.
`ifndef POLYLINE_SIMPLIFIER_MACROS_SVH
`define POLYLINE_SIMPLIFIER_MACROS_SVH

// Checked only while out of reset.
`define PLS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PLS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/plsimp_pkg.sv
package plsimp_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 12;
    localparam int EPS_W      = 16;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd16;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    // datapath widths
    localparam int D_W    = COORD_BITS + 1;       // signed coordinate difference
    localparam int P_W    = 2 * D_W;              // signed product
    localparam int L_W    = 2 * COORD_BITS + 1;   // squared length
    localparam int M_W    = L_W;                  // |cross| or squared distance
    localparam int MS_W   = M_W + 4;
    localparam int MA_W   = 2 * MS_W;
    localparam int E2_W   = 2 * EPS_W;
    localparam int MB_W   = E2_W + L_W;
    localparam int CMP_W  = (MA_W > MB_W) ? MA_W : MB_W;

    localparam int CQ_DEPTH = 4;
    localparam int CQ_PW    = $clog2(CQ_DEPTH);
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

    typedef struct packed {
        logic                  store;
        logic                  run;
        logic [IDX_W-1:0]      idx;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [CNT_W-1:0]      n;
        logic                  ovf;
    } t_cmd;

    typedef enum logic [4:0] {
        B_IDLE,
        B_POP,
        B_SEG,
        B_GET_S,
        B_GET_E,
        B_LEN,
        B_PT_A,
        B_PT_B,
        B_PT_C,
        B_CMP_A,
        B_CMP_B,
        B_CMP_C,
        B_PUSH2,
        B_EMIT_RD,
        B_EMIT_WR,
        B_FEW,
        B_DONE
    } t_bstate;

endpackage

### hdl/plsimp_front.sv
module plsimp_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  logic                            i_q_full,
    input  logic [plsimp_pkg::COORD_BITS-1:0] i_point_x,
    input  logic [plsimp_pkg::COORD_BITS-1:0] i_point_y,
    input  logic                            i_final_point,
    output logic                            o_q_push,
    output plsimp_pkg::t_cmd                o_cmd
);
    import plsimp_pkg::*;

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic             accept, room;

    assign accept   = i_push && !i_q_full;
    assign room     = (r_count < CNT_W'(MAX_POINTS));
    assign o_q_push = accept;

    always_comb begin
        o_cmd.store = room;
        o_cmd.run   = i_final_point;
        o_cmd.idx   = r_count[IDX_W-1:0];
        o_cmd.x     = i_point_x;
        o_cmd.y     = i_point_y;
        o_cmd.n     = room ? r_count + CNT_W'(1) : r_count;
        o_cmd.ovf   = r_ovf || !room;
        n_count     = r_count;
        n_ovf       = r_ovf;
        if (accept) begin
            if (i_final_point) begin
                n_count = '0;
                n_ovf   = 1'b0;
            end else begin
                n_count = o_cmd.n;
                n_ovf   = o_cmd.ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

endmodule

### hdl/plsimp_cmdq.sv
module plsimp_cmdq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  plsimp_pkg::t_cmd i_data,
    output logic             o_full,
    input  logic             i_pop,
    output plsimp_pkg::t_cmd o_data,
    output logic             o_empty
);
    import plsimp_pkg::*;

    t_cmd             r_mem [CQ_DEPTH];
    logic [CQ_PW-1:0] r_wr, r_rd;
    logic [CQ_CW-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CQ_CW'(CQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + CQ_PW'(1);
            if (do_pop)  r_rd <= r_rd + CQ_PW'(1);
            r_cnt <= r_cnt + CQ_CW'(do_push) - CQ_CW'(do_pop);
        end
    end

endmodule

### hdl/plsimp_back.sv
module plsimp_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_empty,
    input  plsimp_pkg::t_cmd                  i_cmd,
    output logic                              o_q_pop,
    input  logic                              i_cfg_valid,
    input  logic [plsimp_pkg::EPS_W-1:0]      i_cfg_data,
    input  logic                              i_pop,
    output logic                              o_empty,
    output logic [plsimp_pkg::COORD_BITS-1:0] o_out_x,
    output logic [plsimp_pkg::COORD_BITS-1:0] o_out_y,
    output logic                              o_out_last,
    output logic                              o_too_few,
    output logic                              o_overflowed
);
    import plsimp_pkg::*;

    t_bstate r_state, n_state;

    logic [2*COORD_BITS-1:0] r_pt_mem [MAX_POINTS];
    logic [2*COORD_BITS-1:0] r_pt_rd;
    logic [2*IDX_W-1:0]      r_stk_mem [MAX_POINTS];
    logic [2*IDX_W-1:0]      r_stk_rd;
    logic [MAX_POINTS-1:0]   r_keep;

    logic [EPS_W-1:0]        r_eps;
    logic [CNT_W-1:0]        r_n, r_sp, r_i;
    logic                    r_ovf;
    logic [IDX_W-1:0]        r_s, r_e, r_bidx;
    logic [COORD_BITS-1:0]   r_sx, r_sy;
    logic signed [D_W-1:0]   r_dx, r_dy, r_px, r_py;
    logic [L_W-1:0]          r_sqa, r_sqb, r_len2;
    logic signed [P_W-1:0]   r_pa, r_pb;
    logic [M_W-1:0]          r_best;
    logic [MA_W-1:0]         r_ma;
    logic [E2_W-1:0]         r_e2;
    logic [MB_W-1:0]         r_mb;

    logic                    r_ovalid;
    logic [COORD_BITS-1:0]   r_ox, r_oy;
    logic                    r_olast, r_ofew, r_oovf;

    // control from the sequencer
    logic             pt_we, stk_we, ld_out, out_free, far, len_nz;
    logic [IDX_W-1:0] pt_addr, stk_rd_addr, stk_wr_addr;
    logic [2*IDX_W-1:0] stk_wr_data;

    logic [COORD_BITS-1:0] rd_x, rd_y;
    logic [IDX_W-1:0]      stk_s, stk_e;
    logic signed [P_W-1:0] sq_dx, sq_dy, pr_a, pr_b;
    logic signed [P_W:0]   pdiff, psum;
    logic [M_W-1:0]        m_cur;
    logic [MS_W-1:0]       m16;

    assign rd_x     = r_pt_rd[2*COORD_BITS-1:COORD_BITS];
    assign rd_y     = r_pt_rd[COORD_BITS-1:0];
    assign stk_s    = r_stk_rd[2*IDX_W-1:IDX_W];
    assign stk_e    = r_stk_rd[IDX_W-1:0];
    assign out_free = !r_ovalid || i_pop;
    assign len_nz   = (r_len2 != '0);

    assign sq_dx = r_dx * r_dx;
    assign sq_dy = r_dy * r_dy;
    assign pr_a  = (len_nz ? r_dx : r_px) * (len_nz ? r_py : r_px);
    assign pr_b  = (len_nz ? r_dy : r_py) * (len_nz ? r_px : r_py);
    assign pdiff = {r_pa[P_W-1], r_pa} - {r_pb[P_W-1], r_pb};
    assign psum  = {r_pa[P_W-1], r_pa} + {r_pb[P_W-1], r_pb};
    assign m_cur = len_nz ? (pdiff[P_W] ? M_W'(-pdiff) : M_W'(pdiff)) : M_W'(psum);
    assign m16   = {r_best, 4'b0000};

    assign far = len_nz ? (CMP_W'(r_ma) > CMP_W'(r_mb))
                        : (CMP_W'({r_best, 8'h00}) > CMP_W'(r_e2));

    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        pt_we       = 1'b0;
        stk_we      = 1'b0;
        ld_out      = 1'b0;
        pt_addr     = r_i[IDX_W-1:0];
        stk_rd_addr = IDX_W'(r_sp - CNT_W'(1));
        stk_wr_addr = r_sp[IDX_W-1:0];
        stk_wr_data = {r_s, r_bidx};
        unique case (r_state)
            B_IDLE: begin
                stk_wr_addr = '0;
                stk_wr_data = {IDX_W'(0), IDX_W'(i_cmd.n - CNT_W'(1))};
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    pt_we   = i_cmd.store;
                    if (i_cmd.run) begin
                        if (i_cmd.n < CNT_W'(2)) begin
                            n_state = B_FEW;
                        end else begin
                            stk_we  = 1'b1;
                            n_state = B_POP;
                        end
                    end
                end
            end
            B_POP: begin
                n_state = (r_sp == '0) ? B_EMIT_RD : B_SEG;
            end
            B_SEG: begin
                pt_addr = stk_s;
                if ({1'b0, stk_e} < {1'b0, stk_s} + (IDX_W + 1)'(2)) begin
                    n_state = B_POP;
                end else begin
                    n_state = B_GET_S;
                end
            end
            B_GET_S: begin
                pt_addr = r_e;
                n_state = B_GET_E;
            end
            B_GET_E: begin
                pt_addr = r_s + IDX_W'(1);
                n_state = B_LEN;
            end
            B_LEN:  n_state = B_PT_A;
            B_PT_A: n_state = B_PT_B;
            B_PT_B: n_state = B_PT_C;
            B_PT_C: begin
                pt_addr = IDX_W'(r_i + CNT_W'(1));
                if (r_i + CNT_W'(1) < CNT_W'(r_e)) begin
                    n_state = B_PT_A;
                end else begin
                    n_state = B_CMP_A;
                end
            end
            B_CMP_A: n_state = (r_best == '0) ? B_POP : B_CMP_B;
            B_CMP_B: n_state = B_CMP_C;
            B_CMP_C: begin
                if (far && (CNT_W'(r_sp) + CNT_W'(2) <= CNT_W'(MAX_POINTS))) begin
                    stk_we  = 1'b1;
                    n_state = B_PUSH2;
                end else begin
                    n_state = B_POP;
                end
            end
            B_PUSH2: begin
                stk_we      = 1'b1;
                stk_wr_addr = IDX_W'(r_sp + CNT_W'(1));
                stk_wr_data = {r_bidx, r_e};
                n_state     = B_POP;
            end
            B_EMIT_RD: begin
                if (r_i == r_n) begin
                    n_state = B_DONE;
                end else if (r_keep[r_i[IDX_W-1:0]]) begin
                    n_state = B_EMIT_WR;
                end
            end
            B_EMIT_WR: begin
                if (out_free) begin
                    ld_out  = 1'b1;
                    n_state = B_EMIT_RD;
                end
            end
            B_FEW: begin
                if (out_free) begin
                    ld_out  = 1'b1;
                    n_state = B_DONE;
                end
            end
            B_DONE:  n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // point store and segment stack, registered reads
    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            r_pt_mem[i_cmd.idx] <= {i_cmd.x, i_cmd.y};
        end
        r_pt_rd <= r_pt_mem[pt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_wr_addr] <= stk_wr_data;
        end
        r_stk_rd <= r_stk_mem[stk_rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps    <= EPS_RESET;
            r_keep   <= '0;
            r_sp     <= '0;
            r_i      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_eps <= i_cfg_data;
            if (ld_out) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_q_empty && i_cmd.run && (i_cmd.n >= CNT_W'(2))) begin
                        r_keep[0]                              <= 1'b1;
                        r_keep[IDX_W'(i_cmd.n - CNT_W'(1))]    <= 1'b1;
                        r_sp                                   <= CNT_W'(1);
                    end
                    r_i <= '0;
                end
                B_POP: begin
                    if (r_sp != '0) r_sp <= r_sp - CNT_W'(1);
                    r_i <= '0;
                end
                B_GET_E: r_i <= CNT_W'(r_s) + CNT_W'(1);
                B_PT_C: begin
                    if (r_i + CNT_W'(1) < CNT_W'(r_e)) r_i <= r_i + CNT_W'(1);
                end
                B_CMP_C: begin
                    if (far) r_keep[r_bidx] <= 1'b1;
                end
                B_PUSH2: r_sp <= r_sp + CNT_W'(2);
                B_EMIT_RD: begin
                    // keep bits are cleared one by one as the emit walk passes them
                    if (r_i != r_n) begin
                        r_keep[r_i[IDX_W-1:0]] <= 1'b0;
                        if (!r_keep[r_i[IDX_W-1:0]]) r_i <= r_i + CNT_W'(1);
                    end
                end
                B_EMIT_WR: begin
                    if (out_free) r_i <= r_i + CNT_W'(1);
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty && i_cmd.run) begin
                    r_n   <= i_cmd.n;
                    r_ovf <= i_cmd.ovf;
                end
            end
            B_SEG: begin
                r_s <= stk_s;
                r_e <= stk_e;
            end
            B_GET_S: begin
                r_sx <= rd_x;
                r_sy <= rd_y;
            end
            B_GET_E: begin
                r_dx   <= D_W'(signed'({1'b0, rd_x})) - D_W'(signed'({1'b0, r_sx}));
                r_dy   <= D_W'(signed'({1'b0, rd_y})) - D_W'(signed'({1'b0, r_sy}));
                r_best <= '0;
            end
            B_LEN: begin
                r_sqa <= L_W'(sq_dx);
                r_sqb <= L_W'(sq_dy);
            end
            B_PT_A: begin
                r_px   <= D_W'(signed'({1'b0, rd_x})) - D_W'(signed'({1'b0, r_sx}));
                r_py   <= D_W'(signed'({1'b0, rd_y})) - D_W'(signed'({1'b0, r_sy}));
                r_len2 <= r_sqa + r_sqb;
            end
            B_PT_B: begin
                r_pa <= pr_a;
                r_pb <= pr_b;
            end
            B_PT_C: begin
                // strict compare keeps the first farthest point
                if (m_cur > r_best) begin
                    r_best <= m_cur;
                    r_bidx <= r_i[IDX_W-1:0];
                end
            end
            B_CMP_A: begin
                r_ma <= m16 * m16;
                r_e2 <= r_eps * r_eps;
            end
            B_CMP_B: r_mb <= r_e2 * MB_W'(r_len2);
            default: ;
        endcase
        if (ld_out) begin
            if (r_state == B_FEW) begin
                r_ox    <= '0;
                r_oy    <= '0;
                r_olast <= 1'b1;
                r_ofew  <= 1'b1;
            end else begin
                r_ox    <= rd_x;
                r_oy    <= rd_y;
                r_olast <= (r_i == r_n - CNT_W'(1));
                r_ofew  <= 1'b0;
            end
            r_oovf <= r_ovf;
        end
    end

    assign o_empty      = !r_ovalid;
    assign o_out_x      = r_ox;
    assign o_out_y      = r_oy;
    assign o_out_last   = r_olast;
    assign o_too_few    = r_ofew;
    assign o_overflowed = r_oovf;

endmodule

### hdl/polyline_simplifier.sv
// Load: one point beat per cycle while the 4-deep command queue is not full; the store write
//   follows when the engine is idle. Simplify: per segment the POP, SEG, GET_S, GET_E and LEN
//   setup states and the CMP_A..CMP_C test (plus PUSH2 when it splits), and PT_A, PT_B and PT_C
//   per interior point (one point-store read port). Emit: walks every stored point in order
//   and sends each kept point, waiting while the output beat has not been popped.
// Reset: synchronous, active low; clears counts, stack pointer, keep map, output valid, and
//   sets epsilon to 1.0 px (raw 16). Point store and stack contents are not cleared.
module polyline_simplifier (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // point input, queue style
    input  logic                              push,
    output logic                              full,
    input  logic [plsimp_pkg::COORD_BITS-1:0] i_point_x,
    input  logic [plsimp_pkg::COORD_BITS-1:0] i_point_y,
    input  logic                              i_final_point,
    // epsilon write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [plsimp_pkg::EPS_W-1:0]      i_cfg_data,
    // kept points, queue style
    output logic                              empty,
    input  logic                              pop,
    output logic [plsimp_pkg::COORD_BITS-1:0] o_out_x,
    output logic [plsimp_pkg::COORD_BITS-1:0] o_out_y,
    output logic                              o_out_last,
    output logic                              o_too_few,
    output logic                              o_overflowed
);
    import plsimp_pkg::*;

    t_cmd front_cmd, q_cmd;
    logic q_push, q_full, q_pop, q_empty;

    // the user must change epsilon only while idle; the block does not enforce it, and it is always taken
    assign o_cfg_ready = 1'b1;
    assign full        = q_full;

    // front: counts points, flags drops past capacity, tags the final beat
    plsimp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_q_full      (q_full),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_final_point (i_final_point),
        .o_q_push      (q_push),
        .o_cmd         (front_cmd)
    );

    // short queue lets the front keep taking beats while the engine is busy
    plsimp_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_cmd),
        .o_empty (q_empty)
    );

    // back: point store, segment stack walk, distance test, in-order emit
    plsimp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_cmd        (q_cmd),
        .o_q_pop      (q_pop),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_last   (o_out_last),
        .o_too_few    (o_too_few),
        .o_overflowed (o_overflowed)
    );

endmodule

### hdl/plsimp_chk.sv
`include "polyline_simplifier_macros.svh"

module plsimp_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              full,
    input logic                              empty,
    input logic                              pop,
    input logic [plsimp_pkg::COORD_BITS-1:0] o_out_x,
    input logic [plsimp_pkg::COORD_BITS-1:0] o_out_y,
    input logic                              o_out_last,
    input logic                              o_too_few
);

    `PLS_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> (empty && !full), "not idle after reset")

    `PLS_ASSERT(a_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_last)), "stalled beat changed")

    `PLS_ASSERT(a_few_last, i_clk, i_rst_n, (!empty && o_too_few) |-> o_out_last, "too_few beat not last")

    `PLS_ASSERT(a_few_zero, i_clk, i_rst_n, (!empty && o_too_few) |-> (o_out_x == '0 && o_out_y == '0), "too_few beat has coordinates")

endmodule

bind polyline_simplifier plsimp_chk u_chk (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps

import plsimp_pkg::*;

// Scoreboard: software model of the simplifier plus a queue of expected kept points.
class plsimp_scoreboard;
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  last;
        logic                  few;
        logic                  ovf;
    } t_kept_pt;

    t_kept_pt              kept_q[$];
    logic [EPS_W-1:0]      eps;
    logic [COORD_BITS-1:0] px[MAX_POINTS];
    logic [COORD_BITS-1:0] py[MAX_POINTS];
    bit                    keep[MAX_POINTS];
    int                    count;
    bit                    ovf_flag;
    int                    errors;

    function new();
        eps = EPS_RESET;
        count = 0;
        ovf_flag = 0;
        errors = 0;
    endfunction

    // Segment-stack RDP, exact integer compare.
    function void run_rdp(int n);
        int              seg_s[$];
        int              seg_e[$];
        int              s, e, best;
        longint          dx, dy, qx, qy, len2, m, bestm, cr;
        logic [127:0]    lhs, rhs, e2;
        bit              far;
        keep[0] = 1;
        keep[n-1] = 1;
        seg_s.insert(seg_s.size(), 0);
        seg_e.insert(seg_e.size(), n-1);
        e2 = eps * eps;
        while (seg_s.size() > 0) begin
            s = seg_s.pop_back();
            e = seg_e.pop_back();
            if (e < s + 2) continue;
            dx = longint'(px[e]) - longint'(px[s]);
            dy = longint'(py[e]) - longint'(py[s]);
            len2 = dx*dx + dy*dy;
            bestm = 0;
            best = -1;
            for (int i = s + 1; i < e; i++) begin
                qx = longint'(px[i]) - longint'(px[s]);
                qy = longint'(py[i]) - longint'(py[s]);
                if (len2 != 0) begin
                    cr = dx*qy - dy*qx;
                    m = (cr < 0) ? -cr : cr;
                end else begin
                    m = qx*qx + qy*qy;
                end
                if (m > bestm) begin
                    bestm = m;
                    best = i;
                end
            end
            if (best < 0) continue;
            // chord: squared distance test; zero chord: m is already a squared distance
            if (len2 != 0) begin
                lhs = 128'(bestm) * 128'(bestm) * 256;
                rhs = e2 * 128'(len2);
            end else begin
                lhs = 128'(bestm) * 256;
                rhs = e2;
            end
            far = lhs > rhs;
            if (!far) continue;
            keep[best] = 1;
            if (seg_s.size() + 2 <= MAX_POINTS) begin
                seg_s.insert(seg_s.size(), s);    seg_e.insert(seg_e.size(), best);
                seg_s.insert(seg_s.size(), best); seg_e.insert(seg_e.size(), e);
            end
        end
    endfunction

    // Note one accepted point beat.
    function void note_point(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y, logic fin);
        t_kept_pt k;
        int       lastk;
        if (count < MAX_POINTS) begin
            px[count] = x;
            py[count] = y;
            count++;
        end else begin
            ovf_flag = 1;
        end
        if (!fin) return;
        if (count < 2) begin
            k = '{x: '0, y: '0, last: 1, few: 1, ovf: ovf_flag};
            kept_q.insert(kept_q.size(), k);
        end else begin
            run_rdp(count);
            lastk = 0;
            for (int i = 0; i < count; i++) if (keep[i]) lastk = i;
            for (int i = 0; i < count; i++) begin
                if (!keep[i]) continue;
                k = '{x: px[i], y: py[i], last: (i == lastk), few: 0, ovf: ovf_flag};
                kept_q.insert(kept_q.size(), k);
            end
        end
        count = 0;
        ovf_flag = 0;
        for (int i = 0; i < MAX_POINTS; i++) keep[i] = 0;
    endfunction

    // Compare one popped result with the oldest expectation.
    function void check_result(t_kept_pt got);
        t_kept_pt exp_pt;
        if (kept_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: unexpected result x=%0d y=%0d", got.x, got.y);
            return;
        end
        exp_pt = kept_q.pop_front();
        if (got !== exp_pt) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: exp %0d,%0d l%0b f%0b o%0b got %0d,%0d l%0b f%0b o%0b",
                    exp_pt.x, exp_pt.y, exp_pt.last, exp_pt.few, exp_pt.ovf,
                    got.x, got.y, got.last, got.few, got.ovf);
        end
    endfunction
endclass

module tb_top;
    localparam int WATCHDOG = 200000;

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  push = 0;
    logic                  full;
    logic [COORD_BITS-1:0] i_point_x = '0;
    logic [COORD_BITS-1:0] i_point_y = '0;
    logic                  i_final_point = 0;
    logic                  i_cfg_valid = 0;
    logic                  o_cfg_ready;
    logic [EPS_W-1:0]      i_cfg_data = '0;
    logic                  empty;
    logic                  pop = 0;
    logic [COORD_BITS-1:0] o_out_x;
    logic [COORD_BITS-1:0] o_out_y;
    logic                  o_out_last;
    logic                  o_too_few;
    logic                  o_overflowed;

    plsimp_scoreboard sb = new();
    bit  hold_go = 0;    // starts the receiver hold-off
    bit  hold_pop = 0;   // long receiver hold-off
    int  idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    polyline_simplifier dut (.*);

    // Most gaps short, a few long.
    function automatic int gap_len();
        int r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic bit p_gap();
        return $urandom_range(0, 3) != 0;
    endfunction

    // Drive one point beat, wait for acceptance.
    task automatic send_point(int x, int y, bit fin);
        i_point_x <= x[COORD_BITS-1:0];
        i_point_y <= y[COORD_BITS-1:0];
        i_final_point <= fin;
        push <= 1;
        do @(posedge i_clk); while (full);
        sb.note_point(x[COORD_BITS-1:0], y[COORD_BITS-1:0], fin);
    endtask

    // Gap after a beat: drop push only if a real gap follows.
    task automatic sender_gap(int g);
        if (g > 0) begin
            push <= 0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_polyline(int n, bit random_gaps, int shape);
        int x, y;
        x = $urandom_range(0, 4095);
        y = $urandom_range(0, 4095);
        for (int i = 0; i < n; i++) begin
            case (shape)
                0: begin x = $urandom_range(0, 4095); y = $urandom_range(0, 4095); end
                1: begin   // near-straight walk with jitter
                    x = (x + $urandom_range(0, 40)) % 4096;
                    y = (y + $urandom_range(0, 4)) % 4096;
                end
                default: begin   // collinear and coincident points
                    x = (i % 3 == 0) ? x : (x + 2) % 4096;
                    y = x;
                end
            endcase
            send_point(x, y, i == n - 1);
            if (random_gaps) sender_gap(gap_len());
        end
        push <= 0;
    endtask

    // Wait until every expected beat has been popped, then let the engine settle.
    task automatic drain();
        push <= 0;
        while (sb.kept_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_eps(int v);
        i_cfg_data <= v[EPS_W-1:0];
        i_cfg_valid <= 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        sb.eps = v[EPS_W-1:0];
    endtask

    // Receiver: random pop with gaps; checks on every accepted beat.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty)
                sb.check_result('{x: o_out_x, y: o_out_y, last: o_out_last,
                                  few: o_too_few, ovf: o_overflowed});
            pop <= !hold_pop && ($urandom_range(0, 99) < 70);
        end
    end

    // Watchdog on cycles with no beat accepted anywhere.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("status: fail");
            $finish;
        end
    end

    // Long hold-off on the result side while points keep coming.
    initial begin
        wait (hold_go);
        hold_pop = 1;
        repeat (3000) @(posedge i_clk);
        hold_pop = 0;
    end

    initial begin
        int eps_set[6];
        int sent;
        int n_pts;
        eps_set = '{0, 65535, 1, 16, 40, 300};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: too few points (single, single after final), extremes, ties.
        send_point(0, 0, 1);
        send_point(4095, 4095, 1);
        send_point(0, 0, 0); send_point(4095, 4095, 1);
        send_point(0, 0, 0); send_point(5, 5, 0); send_point(0, 0, 1);   // zero chord
        send_point(0, 0, 0); send_point(100, 3, 0); send_point(100, 3, 0);
        send_point(200, 0, 1);                                          // tie
        send_point(4095, 0, 0); send_point(2048, 4095, 0); send_point(0, 0, 1);
        send_point(10, 10, 0); send_point(10, 10, 1);                    // coincident pair
        drain();
        // Receiver holds off while two full polylines are offered back to back.
        hold_go = 1;
        // Overflow: 66 points, final one dropped.
        for (int i = 0; i < 66; i++)
            send_point((i * 61) % 4096, (i * i * 7) % 4096, i == 65);
        // Full store, final on the last stored point.
        for (int i = 0; i < 64; i++) send_point(i * 64, (i & 1) * 4095, i == 63);
        push <= 0;
        drain();
        sent = 146;

        // Random phases across epsilon settings.
        foreach (eps_set[k]) begin
            write_eps(eps_set[k]);
            n_pts = ($urandom_range(0, 99) < 20) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            send_polyline(n_pts, 1, $urandom_range(0, 2));
            sent += n_pts;
            sender_gap(gap_len());
            drain();
        end
        while (sent < 180) begin
            n_pts = $urandom_range(3, 10);
            send_polyline(n_pts, p_gap(), $urandom_range(0, 2));
            sent += n_pts;
        end
        drain();

        if (sb.errors == 0 && sb.kept_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
